@@ hdl/sps_pkg.sv @@
// ----------------------------------------------------------------------------
// sps_pkg
// Shared types, codes and timing constants of the siren pattern sequencer.
// ----------------------------------------------------------------------------
package sps_pkg;

    localparam int ACTION_W  = 2;
    localparam int PATTERN_W = 3;
    localparam int SECONDS_W = 7;
    localparam int ELAPSED_W = 17;

    // Input action codes
    localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_START = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_STOP  = 2'd2;

    // Pattern codes
    localparam logic [PATTERN_W-1:0] PAT_IDLE      = 3'd0;
    localparam logic [PATTERN_W-1:0] PAT_RISING    = 3'd1;
    localparam logic [PATTERN_W-1:0] PAT_IMMEDIATE = 3'd2;
    localparam logic [PATTERN_W-1:0] PAT_FIRE      = 3'd3;
    localparam logic [PATTERN_W-1:0] PAT_CLEAR     = 3'd4;

    // Timing in milliseconds (the _S constants in seconds)
    localparam int MS_PER_S     = 1000;
    localparam int TOGGLE_MS    = 3000;
    localparam int RISE_HALF_MS = 20000;
    localparam int FIRE_ON_MS   = 20000;
    localparam int FIRE_CYCLE_MS = 35000;

    localparam int LONG_S   = 100;
    localparam int FIRE_S   = 90;
    localparam int SHORT_S  = 60;
    localparam int LONG_MS  = 100000;
    localparam int FIRE_MS  = 90000;
    localparam int SHORT_MS = 60000;

    localparam int CMD_DEPTH_DEF = 2;
    localparam int RES_DEPTH_DEF = 2;

    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_START,
        CMD_STOP,
        CMD_NOP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t              kind;
        logic [PATTERN_W-1:0]   pattern;
    } cmd_t;

    typedef struct packed {
        logic                   siren_on;
        logic [PATTERN_W-1:0]   active_pattern;
        logic                   countdown_show;
        logic [SECONDS_W-1:0]   countdown_seconds;
        logic                   countdown_clear;
    } result_t;

    function automatic logic [ELAPSED_W-1:0] dur_ms(input logic [PATTERN_W-1:0] p);
        logic [ELAPSED_W-1:0] d;
        if (p == PAT_RISING) d = ELAPSED_W'(LONG_MS);
        else if (p == PAT_FIRE) d = ELAPSED_W'(FIRE_MS);
        else d = ELAPSED_W'(SHORT_MS);
        return d;
    endfunction

    function automatic logic [SECONDS_W-1:0] dur_s(input logic [PATTERN_W-1:0] p);
        logic [SECONDS_W-1:0] d;
        if (p == PAT_RISING) d = SECONDS_W'(LONG_S);
        else if (p == PAT_FIRE) d = SECONDS_W'(FIRE_S);
        else d = SECONDS_W'(SHORT_S);
        return d;
    endfunction

endpackage

@@ hdl/siren_pattern_sequencer_unit.sv @@
// ----------------------------------------------------------------------------
// siren_pattern_sequencer_unit
// Timed siren relay sequencer with countdown display events.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive action/pattern and raise push; a transaction is taken
//   on a clock edge with push high and full low. Action 0 is a 1 ms tick,
//   1 starts a pattern (only while idle), 2 stops the siren.
//   Result queue: one result per input transaction. While empty is low the
//   oldest result sits on siren_on, active_pattern, countdown_show,
//   countdown_seconds and countdown_clear; pop with empty low takes it.
//   Path: an input is taken into the classify register, moves on into the
//   command queue, and execute writes its result into the result queue,
//   where it is visible and can be popped.
//   Throughput: one transaction per cycle while results are popped; the
//   execute stage updates all pattern phase counters together per tick.
//   Stall: when the receiver holds off pop, the result queue fills, then the
//   command queue, then full rises; nothing is dropped.
//   Reset: rst_n low clears both queues, sets the siren idle and off.
// ----------------------------------------------------------------------------
module siren_pattern_sequencer_unit #(
    parameter int CMD_DEPTH = sps_pkg::CMD_DEPTH_DEF,
    parameter int RES_DEPTH = sps_pkg::RES_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [sps_pkg::ACTION_W-1:0]  action,
    input  logic [sps_pkg::PATTERN_W-1:0] pattern,
    output logic                          empty,
    input  logic                          pop,
    output logic                          siren_on,
    output logic [sps_pkg::PATTERN_W-1:0] active_pattern,
    output logic                          countdown_show,
    output logic [sps_pkg::SECONDS_W-1:0] countdown_seconds,
    output logic                          countdown_clear
);
    import sps_pkg::*;

    // Front stage to command queue
    logic    front_valid;
    cmd_t    front_cmd;
    logic    cmd_full;
    // Command queue to execute stage
    cmd_t    cmd_head;
    logic    cmd_empty;
    logic    cmd_pop;
    // Execute stage to result queue
    logic    res_full;
    logic    res_push;
    result_t res_in;
    result_t res_head;

    // Classify incoming transactions
    sps_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .action    (action),
        .pattern   (pattern),
        .cmd_valid (front_valid),
        .cmd       (front_cmd),
        .cmd_full  (cmd_full)
    );

    // Decouple classification from execution
    sps_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_valid),
        .wr_data (front_cmd),
        .full    (cmd_full),
        .rd_en   (cmd_pop),
        .rd_data (cmd_head),
        .empty   (cmd_empty)
    );

    // Run pattern timing and produce one result per command
    sps_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd       (cmd_head),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    // Hold results until the receiver pops them
    sps_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_in),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_head),
        .empty   (empty)
    );

    assign siren_on          = res_head.siren_on;
    assign active_pattern    = res_head.active_pattern;
    assign countdown_show    = res_head.countdown_show;
    assign countdown_seconds = res_head.countdown_seconds;
    assign countdown_clear   = res_head.countdown_clear;

endmodule

@@ hdl/sps_fifo.sv @@
// ----------------------------------------------------------------------------
// sps_fifo
// Small synchronous queue with registered storage and occupancy count.
// ----------------------------------------------------------------------------
module sps_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ hdl/sps_front.sv @@
// ----------------------------------------------------------------------------
// sps_front
// Accept input transactions and classify them into sequencer commands.
// ----------------------------------------------------------------------------
module sps_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [sps_pkg::ACTION_W-1:0]  action,
    input  logic [sps_pkg::PATTERN_W-1:0] pattern,
    output logic                       cmd_valid,
    output sps_pkg::cmd_t              cmd,
    input  logic                       cmd_full
);
    import sps_pkg::*;

    logic  cmd_valid_reg, cmd_valid_next;
    cmd_t  cmd_reg, cmd_next;
    logic  take;

    // Stage frees up when empty or when the queue takes its content
    assign full      = cmd_valid_reg && cmd_full;
    assign take      = push && !full;
    assign cmd_valid = cmd_valid_reg;
    assign cmd       = cmd_reg;

    always_comb
    begin
        cmd_next.pattern = pattern;
        unique case (action)
            ACT_TICK:  cmd_next.kind = CMD_TICK;
            ACT_STOP:  cmd_next.kind = CMD_STOP;
            ACT_START:
            begin
                // Drop a start with a pattern code outside the four patterns
                if (pattern >= PAT_RISING && pattern <= PAT_CLEAR)
                    cmd_next.kind = CMD_START;
                else
                    cmd_next.kind = CMD_NOP;
            end
            default:   cmd_next.kind = CMD_NOP;
        endcase
        cmd_valid_next = take ? 1'b1 : (cmd_valid_reg && cmd_full);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

@@ hdl/sps_back.sv @@
// ----------------------------------------------------------------------------
// sps_back
// Execute commands: pattern timing counters, relay level and countdown.
// ----------------------------------------------------------------------------
module sps_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_empty,
    input  sps_pkg::cmd_t     cmd,
    output logic              cmd_pop,
    input  logic              res_full,
    output logic              res_push,
    output sps_pkg::result_t  res
);
    import sps_pkg::*;

    logic [PATTERN_W-1:0] run_reg, run_next;
    logic [ELAPSED_W-1:0] elapsed_reg, elapsed_next;
    logic [SECONDS_W-1:0] shown_reg, shown_next;
    logic                 relay_reg, relay_next;
    logic [9:0]           ms_reg, ms_next;
    logic [SECONDS_W-1:0] sec_reg, sec_next;
    logic [11:0]          m3_reg, m3_next;
    logic                 p3_reg, p3_next;
    logic [14:0]          m20_reg, m20_next;
    logic                 p20_reg, p20_next;
    logic [11:0]          m3a_reg, m3a_next;
    logic                 p3a_reg, p3a_next;
    logic [15:0]          m35_reg, m35_next;

    logic                 go;
    logic                 level;
    logic [SECONDS_W-1:0] total;

    assign go       = !cmd_empty && !res_full;
    assign cmd_pop  = go;
    assign res_push = go;
    assign total    = dur_s(run_reg);

    always_comb
    begin
        unique case (run_reg)
            PAT_RISING:    level = !p20_reg || p3a_reg;
            PAT_IMMEDIATE: level = !p3_reg;
            PAT_FIRE:      level = (m35_reg < 16'(FIRE_ON_MS));
            default:       level = 1'b1;
        endcase
    end

    always_comb
    begin
        run_next     = run_reg;
        elapsed_next = elapsed_reg;
        shown_next   = shown_reg;
        relay_next   = relay_reg;
        ms_next      = ms_reg;
        sec_next     = sec_reg;
        m3_next      = m3_reg;
        p3_next      = p3_reg;
        m20_next     = m20_reg;
        p20_next     = p20_reg;
        m3a_next     = m3a_reg;
        p3a_next     = p3a_reg;
        m35_next     = m35_reg;
        res.countdown_show    = 1'b0;
        res.countdown_seconds = '0;
        res.countdown_clear   = 1'b0;

        unique case (cmd.kind)
            CMD_START:
            begin
                if (run_reg == PAT_IDLE)
                begin
                    run_next     = cmd.pattern;
                    elapsed_next = '0;
                    shown_next   = '0;
                    ms_next      = '0;
                    sec_next     = '0;
                    m3_next      = '0;
                    p3_next      = 1'b0;
                    m20_next     = '0;
                    p20_next     = 1'b0;
                    m3a_next     = '0;
                    p3a_next     = 1'b0;
                    m35_next     = '0;
                end
            end
            CMD_STOP:
            begin
                relay_next          = 1'b0;
                run_next            = PAT_IDLE;
                res.countdown_clear = 1'b1;
            end
            CMD_TICK:
            begin
                if (run_reg != PAT_IDLE)
                begin
                    if (sec_reg >= shown_reg)
                    begin
                        res.countdown_show    = 1'b1;
                        res.countdown_seconds = (total >= shown_reg) ? total - shown_reg : '0;
                        shown_next            = shown_reg + 1'b1;
                    end
                    if (elapsed_reg > dur_ms(run_reg))
                    begin
                        relay_next          = 1'b0;
                        run_next            = PAT_IDLE;
                        res.countdown_clear = 1'b1;
                    end
                    else
                    begin
                        relay_next = level;
                    end
                    // Advance the elapsed count and every phase counter
                    if (elapsed_reg != '1)
                        elapsed_next = elapsed_reg + 1'b1;
                    if (ms_reg == 10'(MS_PER_S - 1))
                    begin
                        ms_next  = '0;
                        sec_next = sec_reg + 1'b1;
                    end
                    else
                    begin
                        ms_next = ms_reg + 1'b1;
                    end
                    if (m3_reg == 12'(TOGGLE_MS - 1))
                    begin
                        m3_next = '0;
                        p3_next = !p3_reg;
                    end
                    else
                    begin
                        m3_next = m3_reg + 1'b1;
                    end
                    if (m20_reg == 15'(RISE_HALF_MS - 1))
                    begin
                        m20_next = '0;
                        p20_next = !p20_reg;
                        m3a_next = '0;
                        p3a_next = 1'b0;
                    end
                    else
                    begin
                        m20_next = m20_reg + 1'b1;
                        if (m3a_reg == 12'(TOGGLE_MS - 1))
                        begin
                            m3a_next = '0;
                            p3a_next = !p3a_reg;
                        end
                        else
                        begin
                            m3a_next = m3a_reg + 1'b1;
                        end
                    end
                    m35_next = (m35_reg == 16'(FIRE_CYCLE_MS - 1)) ? '0 : m35_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        res.siren_on       = relay_next;
        res.active_pattern = run_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg     <= PAT_IDLE;
            elapsed_reg <= '0;
            shown_reg   <= '0;
            relay_reg   <= 1'b0;
            ms_reg      <= '0;
            sec_reg     <= '0;
            m3_reg      <= '0;
            p3_reg      <= 1'b0;
            m20_reg     <= '0;
            p20_reg     <= 1'b0;
            m3a_reg     <= '0;
            p3a_reg     <= 1'b0;
            m35_reg     <= '0;
        end
        else if (go)
        begin
            run_reg     <= run_next;
            elapsed_reg <= elapsed_next;
            shown_reg   <= shown_next;
            relay_reg   <= relay_next;
            ms_reg      <= ms_next;
            sec_reg     <= sec_next;
            m3_reg      <= m3_next;
            p3_reg      <= p3_next;
            m20_reg     <= m20_next;
            p20_reg     <= p20_next;
            m3a_reg     <= m3a_next;
            p3a_reg     <= p3a_next;
            m35_reg     <= m35_next;
        end
    end

endmodule

@@ tb/siren_pattern_sequencer_unit_test.sv @@
// ----------------------------------------------------------------------------
// siren_pattern_sequencer_unit_test
// Self-checking testbench for the siren pattern sequencer. Directed commands
// cover idle ticks, stray stops, bad and ignored starts, and every pattern.
// Random bursts follow. Each result is checked against an in-bench
// prediction while both queue sides idle at random and the result side is
// held off once at length.
// ----------------------------------------------------------------------------
module siren_pattern_sequencer_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    import sps_pkg::*;

    // Action 3 is not a command; the block reports its current levels.
    localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;

    localparam int RANDOM_ITEMS    = 800;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 12;
    localparam int CYCLE_LIMIT     = 4000000;

    // ------------------------------------------------------------------------
    // Siren prediction and result checking
    // ------------------------------------------------------------------------
    class siren_report_checker;

        logic [PATTERN_W-1:0] run_pat    = PAT_IDLE;
        int unsigned          elapsed    = 0;
        int unsigned          secs_shown = 0;
        bit                   relay      = 1'b0;
        result_t              reports_due[$];
        int                   failures   = 0;

        static function int unsigned span_ms(logic [PATTERN_W-1:0] p);
            case (p)
                PAT_RISING: return LONG_MS;
                PAT_FIRE:   return FIRE_MS;
                default:    return SHORT_MS;
            endcase
        endfunction

        function bit level_at(logic [PATTERN_W-1:0] p, int unsigned e);
            case (p)
                PAT_RISING:
                begin
                    if ((e / RISE_HALF_MS) % 2 == 0)
                        return 1'b1;
                    return ((e % RISE_HALF_MS) / TOGGLE_MS) % 2 == 1;
                end
                PAT_IMMEDIATE: return (e / TOGGLE_MS) % 2 == 0;
                PAT_FIRE:      return (e % FIRE_CYCLE_MS) < FIRE_ON_MS;
                default:       return 1'b1;
            endcase
        endfunction

        function void note_command(logic [ACTION_W-1:0] act, logic [PATTERN_W-1:0] pat);
            result_t     r;
            int unsigned ms_total;
            int unsigned s_total;
            r = '0;
            case (act)
                ACT_START:
                begin
                    if (run_pat == PAT_IDLE && pat >= PAT_RISING && pat <= PAT_CLEAR)
                    begin
                        run_pat    = pat;
                        elapsed    = 0;
                        secs_shown = 0;
                    end
                end
                ACT_STOP:
                begin
                    relay             = 1'b0;
                    run_pat           = PAT_IDLE;
                    r.countdown_clear = 1'b1;
                end
                ACT_TICK:
                begin
                    if (run_pat != PAT_IDLE)
                    begin
                        ms_total = span_ms(run_pat);
                        s_total  = ms_total / MS_PER_S;
                        if (elapsed / MS_PER_S >= secs_shown)
                        begin
                            r.countdown_show    = 1'b1;
                            r.countdown_seconds = (s_total >= secs_shown) ?
                                SECONDS_W'(s_total - secs_shown) : '0;
                            secs_shown = (secs_shown + 1) & 32'h7F;
                        end
                        if (elapsed > ms_total)
                        begin
                            relay             = 1'b0;
                            run_pat           = PAT_IDLE;
                            r.countdown_clear = 1'b1;
                        end
                        else
                        begin
                            relay = level_at(run_pat, elapsed);
                        end
                        if (elapsed < 32'h1FFFF)
                            elapsed++;
                    end
                end
                default: ;
            endcase
            r.siren_on       = relay;
            r.active_pattern = run_pat;
            reports_due.push_back(r);
        endfunction

        function void match_field(string name, logic [SECONDS_W-1:0] want,
                                  logic [SECONDS_W-1:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                failures++;
            end
        endfunction

        function void check_report(result_t got);
            result_t want;
            if (reports_due.size() == 0)
            begin
                $error("result popped with no transaction outstanding");
                failures++;
                return;
            end
            want = reports_due.pop_front();
            match_field("siren_on", SECONDS_W'(want.siren_on), SECONDS_W'(got.siren_on));
            match_field("active_pattern", SECONDS_W'(want.active_pattern),
                        SECONDS_W'(got.active_pattern));
            match_field("countdown_show", SECONDS_W'(want.countdown_show),
                        SECONDS_W'(got.countdown_show));
            match_field("countdown_seconds", want.countdown_seconds, got.countdown_seconds);
            match_field("countdown_clear", SECONDS_W'(want.countdown_clear),
                        SECONDS_W'(got.countdown_clear));
        endfunction

        function int waiting();
            return reports_due.size();
        endfunction

    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block
    // ------------------------------------------------------------------------
    logic                 clk     = 1'b0;
    logic                 rst_n   = 1'b0;
    logic                 push    = 1'b0;
    logic                 full;
    logic [ACTION_W-1:0]  action  = ACT_TICK;
    logic [PATTERN_W-1:0] pattern = PAT_IDLE;
    logic                 empty;
    logic                 pop     = 1'b0;
    logic                 siren_on;
    logic [PATTERN_W-1:0] active_pattern;
    logic                 countdown_show;
    logic [SECONDS_W-1:0] countdown_seconds;
    logic                 countdown_clear;

    siren_report_checker reports;

    // Idle odds in percent per transaction (sender) or per pop run (receiver).
    int send_idle_pct = 20;
    int recv_idle_pct = 20;
    bit hold_off_due  = 1'b0;
    int cycle_count   = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    siren_pattern_sequencer_unit dut (.*);

    // ------------------------------------------------------------------------
    // Watchdog: end the run at the cycle limit, as a guard against a loss of progress
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Monitors: sample both handshakes on the clock edge that completes them.
    // Predict on every accepted command, check every popped result.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
                reports.note_command(action, pattern);
            if (pop && !empty)
                reports.check_report({siren_on, active_pattern, countdown_show,
                                      countdown_seconds, countdown_clear});
        end
    end

    // Pick an idle stretch: mostly none, a few short ones, now and then a long one.
    function automatic int idle_len(int pct);
        if ($urandom_range(0, 99) >= pct)
            return 0;
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Offer one transaction and hold it until the block takes it.
    task automatic offer(input logic [ACTION_W-1:0] act, input logic [PATTERN_W-1:0] pat);
        int gap;
        gap = idle_len(send_idle_pct);
        if (gap > 0)
        begin
            // Drop push and scramble the fields while idle.
            push    <= 1'b0;
            action  <= ACTION_W'($urandom);
            pattern <= PATTERN_W'($urandom);
            repeat (gap) @(posedge clk);
        end
        push    <= 1'b1;
        action  <= act;
        pattern <= pat;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    task automatic tick_burst(input int n);
        repeat (n) offer(ACT_TICK, PATTERN_W'($urandom));
    endtask

    // ------------------------------------------------------------------------
    // Receiver: pop in runs with random idle stretches; on request hold off
    // for a long stretch so the block backs up and raises full.
    // ------------------------------------------------------------------------
    initial
    begin
        int run;
        int gap;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_off_due)
            begin
                hold_off_due = 1'b0;
                pop <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            pop <= 1'b1;
            run = $urandom_range(1, 20);
            repeat (run) @(posedge clk);
            gap = idle_len(recv_idle_pct);
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender: directed commands, then random bursts
    // ------------------------------------------------------------------------
    initial
    begin
        int counted;
        int len;
        reports = new;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Idle corner cases: a tick must not advance, a stray stop still
        // clears, a non-command reports levels, bad patterns never start.
        offer(ACT_TICK, PAT_IDLE);
        offer(ACT_STOP, PAT_CLEAR);
        offer(ACT_NONE, PAT_FIRE);
        offer(ACT_START, PAT_IDLE);
        for (int p = PAT_CLEAR + 1; p < 2 ** PATTERN_W; p++)
            offer(ACT_START, PATTERN_W'(p));

        // Start holds the relay until the first tick; a second start is ignored.
        offer(ACT_START, PAT_RISING);
        offer(ACT_START, PAT_IMMEDIATE);
        tick_burst(2);
        offer(ACT_NONE, PAT_CLEAR);
        tick_burst(1);
        offer(ACT_STOP, PAT_RISING);
        offer(ACT_TICK, PAT_RISING);

        // Touch each remaining pattern briefly, stopping mid-run.
        offer(ACT_START, PAT_IMMEDIATE);
        tick_burst(1);
        offer(ACT_STOP, PAT_IDLE);
        offer(ACT_START, PAT_FIRE);
        tick_burst(2);
        offer(ACT_STOP, PAT_IDLE);
        offer(ACT_START, PAT_CLEAR);
        tick_burst(1);
        offer(ACT_STOP, PAT_IDLE);

        // Random bursts: mostly start, ticks, maybe stop; some raw noise.
        // Ask the receiver for its long hold-off right away.
        hold_off_due = 1'b1;
        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 2))
                0:       send_idle_pct = 0;
                1:       send_idle_pct = 15;
                default: send_idle_pct = 50;
            endcase
            case ($urandom_range(0, 2))
                0:       recv_idle_pct = 0;
                1:       recv_idle_pct = 15;
                default: recv_idle_pct = 50;
            endcase
            if ($urandom_range(0, 9) < 8)
            begin
                offer(ACT_START, PATTERN_W'($urandom_range(PAT_RISING, PAT_CLEAR)));
                len = $urandom_range(1, 60);
                for (int i = 0; i < len; i++)
                begin
                    if ($urandom_range(0, 19) == 0)
                        offer(ACT_START, PATTERN_W'($urandom));
                    offer(ACT_TICK, PATTERN_W'($urandom));
                end
                counted += len + 1;
                if ($urandom_range(0, 9) < 6)
                begin
                    offer(ACT_STOP, PATTERN_W'($urandom));
                    counted++;
                end
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                    offer(ACTION_W'($urandom), PATTERN_W'($urandom));
            end
        end

        // Drain: release push, wait out every outstanding result, then wait
        // out DRAIN_CYCLES so stray results can show up.
        push <= 1'b0;
        @(posedge clk);
        while (reports.waiting() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (reports.failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
